/* hdl/conv2d_valid_stream_macros.svh */
// Assertion macros shared by the conv2d stream modules
`ifndef CONV2D_VALID_STREAM_MACROS_SVH
`define CONV2D_VALID_STREAM_MACROS_SVH

// implication checked on every clock, off in reset
`define C2D_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%s failed", "lbl");

// implication checked in the cycle after the antecedent
`define C2D_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%s failed", "lbl");

`endif

/* hdl/c2d_pkg.sv */
// Shared types and constants of the conv2d stream block
package c2d_pkg;
  localparam int unsigned MaxFrame   = 32;
  localparam int unsigned MaxKernel  = 5;
  localparam int unsigned DataWidth  = 16;
  localparam int unsigned SumWidth   = 38;
  localparam int unsigned PosWidth   = 5;
  localparam int unsigned KWidth     = 3;
  localparam int unsigned FWidth     = 6;
  localparam int unsigned RowsWidth  = $clog2(MaxKernel);
  localparam int unsigned StoreDepth = MaxKernel * MaxFrame;
  localparam int unsigned StoreAw    = $clog2(StoreDepth);
  localparam int unsigned WDepth     = MaxKernel * MaxKernel;
  localparam int unsigned WAw        = $clog2(WDepth);
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 6;

  localparam logic [CfgIdxW-1:0] RegFrameSize  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegKernelSize = 1'b1;

  localparam logic FuncWeight = 1'b0;
  localparam logic FuncSample = 1'b1;

  typedef struct packed {
    logic                        func;
    logic [2:0]                  weight_row;
    logic [2:0]                  weight_col;
    logic signed [DataWidth-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [SumWidth-1:0] sum;
    logic [PosWidth-1:0]        out_row;
    logic [PosWidth-1:0]        out_col;
    logic                       last;
  } out_item_t;

  // job handed from front to back: one window to evaluate
  typedef struct packed {
    logic [RowsWidth-1:0] slot0;   // row-store slot of window top row
    logic [PosWidth-1:0]  c0;
    logic [KWidth-1:0]    k;
    logic [PosWidth-1:0]  r0;
    logic                 last;
  } job_t;

  // row-store write request from front to back
  typedef struct packed {
    logic                        en;
    logic [StoreAw-1:0]          addr;
    logic signed [DataWidth-1:0] data;
  } swr_t;

  typedef struct packed {
    logic                        en;
    logic [WAw-1:0]              addr;
    logic signed [DataWidth-1:0] data;
  } wwr_t;
endpackage

/* hdl/c2d_front.sv */
// Front end: accepts requests, tracks frame position, issues window jobs
module c2d_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [c2d_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [c2d_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  c2d_pkg::in_item_t         in_data_i,
  input  logic                      busy_i,
  output logic                      job_valid_o,
  input  logic                      job_ready_i,
  output c2d_pkg::job_t             job_o,
  output c2d_pkg::swr_t             swr_o,
  output c2d_pkg::wwr_t             wwr_o
);
  import c2d_pkg::*;

  logic [FWidth-1:0]   frame_q;
  logic [KWidth-1:0]   kern_q;
  logic [PosWidth-1:0] row_q, col_q;
  logic [RowsWidth-1:0] slot_q;   // row_q mod MaxKernel
  logic [FWidth-1:0]   f_eff;
  logic [KWidth-1:0]   k_eff;
  logic                acc, is_smp, last_w, emit, col_end, row_end;
  logic [PosWidth:0]   km1;
  logic [RowsWidth-1:0] slot0;
  logic [RowsWidth:0]  slot_sum;

  always_comb begin
    f_eff = frame_q;
    if (frame_q == '0) f_eff = FWidth'(1);
    else if (frame_q > FWidth'(MaxFrame)) f_eff = FWidth'(MaxFrame);
    k_eff = kern_q;
    if (kern_q == '0) k_eff = KWidth'(1);
    else if (kern_q > KWidth'(MaxKernel)) k_eff = KWidth'(MaxKernel);
  end

  // no request while a window is in flight: the back end still reads both stores
  assign km1     = (PosWidth+1)'(k_eff) - (PosWidth+1)'(1);
  assign is_smp  = (in_data_i.func == FuncSample);
  assign col_end = ({1'b0, col_q} >= (PosWidth+1)'(f_eff - FWidth'(1)));
  assign row_end = ({1'b0, row_q} >= (PosWidth+1)'(f_eff - FWidth'(1)));
  assign last_w  = col_end && row_end;
  assign emit    = is_smp && ({3'b0, k_eff} <= f_eff) && ({1'b0, row_q} >= km1)
                   && ({1'b0, col_q} >= km1);
  assign in_ready_o = !busy_i && (!emit || job_ready_i);
  assign acc        = in_valid_i && in_ready_o;

  assign slot_sum = {1'b0, slot_q} + (RowsWidth+1)'(MaxKernel) - (RowsWidth+1)'(km1);
  assign slot0 = (slot_sum >= (RowsWidth+1)'(MaxKernel))
                 ? RowsWidth'(slot_sum - (RowsWidth+1)'(MaxKernel))
                 : RowsWidth'(slot_sum);

  assign job_valid_o  = in_valid_i && emit && !busy_i;
  assign job_o.slot0  = slot0;
  assign job_o.c0     = PosWidth'({1'b0, col_q} - km1);
  assign job_o.r0     = PosWidth'({1'b0, row_q} - km1);
  assign job_o.k      = k_eff;
  assign job_o.last   = last_w;

  assign swr_o.en   = acc && is_smp;
  assign swr_o.addr = StoreAw'(slot_q) * StoreAw'(MaxFrame) + StoreAw'(col_q);
  assign swr_o.data = in_data_i.value;
  assign wwr_o.en   = acc && !is_smp && (in_data_i.weight_row < 3'(MaxKernel))
                      && (in_data_i.weight_col < 3'(MaxKernel));
  assign wwr_o.addr = WAw'(in_data_i.weight_row) * WAw'(MaxKernel)
                      + WAw'(in_data_i.weight_col);
  assign wwr_o.data = in_data_i.value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= FWidth'(28);
      kern_q  <= KWidth'(5);
      row_q   <= '0;
      col_q   <= '0;
      slot_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegFrameSize:  frame_q <= cfg_data_i;
        RegKernelSize: kern_q  <= cfg_data_i[KWidth-1:0];
        default: ;
      endcase
      row_q  <= '0;
      col_q  <= '0;
      slot_q <= '0;
    end else if (acc && is_smp) begin
      if (col_end) begin
        col_q <= '0;
        if (row_end) begin
          row_q  <= '0;
          slot_q <= '0;
        end else begin
          row_q  <= row_q + PosWidth'(1);
          slot_q <= (slot_q == RowsWidth'(MaxKernel-1)) ? '0 : slot_q + RowsWidth'(1);
        end
      end else begin
        col_q <= col_q + PosWidth'(1);
      end
    end
  end

  `include "conv2d_valid_stream_macros.svh"
  `C2D_ASSERT_IMP(a_slot_range, 1'b1, slot_q < RowsWidth'(MaxKernel))
  `C2D_ASSERT_IMP(a_job_needs_sample, job_valid_o, is_smp)
  `C2D_ASSERT_IMP(a_col_in_frame, 1'b1, {1'b0, col_q} < (PosWidth+1)'(MaxFrame))
  `C2D_ASSERT_IMP(a_no_req_busy, busy_i, !acc)
endmodule

/* hdl/c2d_queue.sv */
// Short two-entry queue of window jobs between front and back
module c2d_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  c2d_pkg::job_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output c2d_pkg::job_t rd_data_o
);
  import c2d_pkg::*;

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

  `include "conv2d_valid_stream_macros.svh"
  `C2D_ASSERT_IMP(a_cnt_max, 1'b1, cnt_q <= 2'd2)
  `C2D_ASSERT_NEXT(a_wr_only, wr && !rd, cnt_q == $past(cnt_q) + 2'd1)
  `C2D_ASSERT_NEXT(a_rd_only, rd && !wr, cnt_q == $past(cnt_q) - 2'd1)
endmodule

/* hdl/c2d_back.sv */
// Back end: stores, walks the window with one multiplier, holds the result
module c2d_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  c2d_pkg::swr_t     swr_i,
  input  c2d_pkg::wwr_t     wwr_i,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  input  c2d_pkg::job_t     job_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output c2d_pkg::out_item_t out_data_o
);
  import c2d_pkg::*;

  typedef enum logic [1:0] {StIdle, StRun, StDrain} state_e;

  logic signed [DataWidth-1:0] store_q [StoreDepth];
  logic signed [DataWidth-1:0] wmem_q [WDepth];
  logic signed [DataWidth-1:0] s_rd_q, w_rd_q;
  logic signed [2*DataWidth-1:0] prod_q;
  logic signed [SumWidth-1:0] acc_q;
  state_e               st_q;
  job_t                 job_q;
  logic [KWidth-1:0]    i_q, j_q;
  logic [RowsWidth-1:0] slot_q;
  logic                 rdv_q, pv_q, done_q;
  logic                 issue, step_last, out_free, fire;
  logic [StoreAw-1:0]   s_addr;
  logic [WAw-1:0]       w_addr;
  out_item_t            res_q;
  logic                 res_v_q;

  assign issue     = (st_q == StRun);
  assign step_last = (i_q == job_q.k - KWidth'(1)) && (j_q == job_q.k - KWidth'(1));
  assign s_addr    = StoreAw'(slot_q) * StoreAw'(MaxFrame) + StoreAw'(job_q.c0)
                     + StoreAw'(j_q);
  assign w_addr    = WAw'(i_q) * WAw'(MaxKernel) + WAw'(j_q);
  assign out_free  = !res_v_q || out_ready_i;
  assign fire      = (st_q == StDrain) && !rdv_q && !pv_q && out_free;
  assign job_ready_o = (st_q == StIdle);
  assign out_valid_o = res_v_q;
  assign out_data_o  = res_q;

  // memories: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (swr_i.en) store_q[swr_i.addr] <= swr_i.data;
    if (wwr_i.en) wmem_q[wwr_i.addr] <= wwr_i.data;
    s_rd_q <= store_q[s_addr];
    w_rd_q <= wmem_q[w_addr];
    prod_q <= s_rd_q * w_rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; i_q <= '0; j_q <= '0; slot_q <= '0;
      rdv_q <= 1'b0; pv_q <= 1'b0; done_q <= 1'b0;
      acc_q <= '0; res_v_q <= 1'b0; job_q <= '0; res_q <= '0;
    end else begin
      rdv_q  <= issue;
      pv_q   <= rdv_q;
      done_q <= fire;
      if (st_q == StIdle && job_valid_i) acc_q <= '0;
      else if (pv_q) acc_q <= acc_q + SumWidth'(prod_q);
      if (fire) res_v_q <= 1'b1;
      else if (out_ready_i) res_v_q <= 1'b0;
      unique case (st_q)
        StIdle: if (job_valid_i) begin
          job_q <= job_i; slot_q <= job_i.slot0;
          i_q <= '0; j_q <= '0;
          st_q <= StRun;
        end
        StRun: begin
          if (step_last) begin
            st_q <= StDrain;
          end else if (j_q == job_q.k - KWidth'(1)) begin
            j_q <= '0; i_q <= i_q + KWidth'(1);
            slot_q <= (slot_q == RowsWidth'(MaxKernel-1)) ? '0 : slot_q + RowsWidth'(1);
          end else begin
            j_q <= j_q + KWidth'(1);
          end
        end
        StDrain: if (fire) begin
          res_q.sum     <= acc_q;
          res_q.out_row <= job_q.r0;
          res_q.out_col <= job_q.c0;
          res_q.last    <= job_q.last;
          st_q    <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  `include "conv2d_valid_stream_macros.svh"
  `C2D_ASSERT_IMP(a_idle_no_pipe, st_q == StIdle && !done_q, !rdv_q && !pv_q)
  `C2D_ASSERT_NEXT(a_done_valid, fire, res_v_q)
  `C2D_ASSERT_IMP(a_idx_range, st_q == StRun, i_q < job_q.k && j_q < job_q.k)
endmodule

/* hdl/conv2d_valid_stream.sv */
// Streaming square 2D valid convolution: one sample or weight per request;
// each sample completing a KxK window yields one signed 38-bit (Q38.0) sum,
// computed by the single multiply-accumulate unit walking the window one tap
// per cycle through the store read, product and accumulator registers. No
// request is taken while a window is in flight, so such a sample holds the
// input until its sum is registered at the output, longer while an earlier
// result waits there. Weights and samples never written read as undefined.
module conv2d_valid_stream (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [c2d_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [c2d_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  c2d_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output c2d_pkg::out_item_t           out_data_o
);
  import c2d_pkg::*;

  logic  fj_valid, fj_ready, bj_valid, bj_ready, busy;
  job_t  fj, bj;
  swr_t  swr;
  wwr_t  wwr;

  // a window is in flight while queued or while the back end is not idle
  assign busy = bj_valid || !bj_ready;

  c2d_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .in_data_i, .busy_i(busy),
    .job_valid_o(fj_valid), .job_ready_i(fj_ready), .job_o(fj),
    .swr_o(swr), .wwr_o(wwr)
  );

  c2d_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(fj_valid), .wr_ready_o(fj_ready), .wr_data_i(fj),
    .rd_valid_o(bj_valid), .rd_ready_i(bj_ready), .rd_data_o(bj)
  );

  c2d_back u_back (
    .clk_i, .rst_ni, .swr_i(swr), .wwr_i(wwr),
    .job_valid_i(bj_valid), .job_ready_o(bj_ready), .job_i(bj),
    .out_valid_o, .out_ready_i, .out_data_o
  );
endmodule
